FILE: rtl/gmfm_pkg.sv
package gmfm_pkg;

    localparam int MAX_COLS  = 32;
    localparam int MAX_ROWS  = 32;
    localparam int TYPE_BITS = 8;

    localparam int CELL_BITS = TYPE_BITS + 2;
    localparam int CELLS     = MAX_COLS * MAX_ROWS;
    localparam int ADDR_BITS = $clog2(CELLS);

    // fixed field widths of the words on the ports
    localparam int ACT_BITS  = 2;
    localparam int POS_BITS  = 5;
    localparam int VTYP_BITS = 8;
    localparam int SIGN_BITS = 2;
    localparam int SIZE_BITS = 6;
    localparam int CFG_BITS  = 6;
    localparam int EXT_BITS  = 6;
    localparam int SUM_BITS  = SIZE_BITS + 1;

    localparam int S_DATA_BITS = 56;
    localparam int M_DATA_BITS = 8;

    // action codes
    localparam logic [ACT_BITS-1:0] ACT_SET    = 2'd0;
    localparam logic [ACT_BITS-1:0] ACT_WIDTH  = 2'd1;
    localparam logic [ACT_BITS-1:0] ACT_HEIGHT = 2'd2;
    localparam logic [ACT_BITS-1:0] ACT_CLEAR  = 2'd3;

    // face sign codes
    localparam logic [SIGN_BITS-1:0] SIGN_NONE = 2'b00;
    localparam logic [SIGN_BITS-1:0] SIGN_POS  = 2'b01;
    localparam logic [SIGN_BITS-1:0] SIGN_NEG  = 2'b11;

    // configuration register indexes
    localparam logic CFG_COLS = 1'b0;
    localparam logic CFG_ROWS = 1'b1;

    localparam logic [CFG_BITS-1:0] CFG_RESET_COLS = 6'd32;
    localparam logic [CFG_BITS-1:0] CFG_RESET_ROWS = 6'd32;

    typedef logic [CELL_BITS-1:0] cell_t;

    typedef struct packed {
        logic load;
        logic set_we;
        logic clr_we;
        logic rd_en;
        logic ext_inc;
        logic k_inc;
        logic k_clr;
        logic l_inc;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic [ACT_BITS-1:0] action;
        logic                w_end;
        logic                h_end;
        logic                wclip_zero;
        logic                hclip_zero;
        logic                k_last;
        logic                l_last;
        logic                match;
        logic                out_full;
    } dp_stat_t;

    function automatic logic [ADDR_BITS-1:0] cell_addr(
        input logic [POS_BITS-1:0] row,
        input logic [POS_BITS-1:0] col
    );
        logic [ADDR_BITS+POS_BITS-1:0] full;
        full = (ADDR_BITS+POS_BITS)'(row) * (ADDR_BITS+POS_BITS)'(MAX_COLS)
             + (ADDR_BITS+POS_BITS)'(col);
        return full[ADDR_BITS-1:0];
    endfunction

endpackage

FILE: rtl/gmfm_ram.sv
module gmfm_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: rtl/gmfm_ctrl.sv
module gmfm_ctrl
    import gmfm_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     in_valid,
    output logic     in_ready,
    input  logic     out_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_START  = 4'd1;
    localparam logic [3:0] ST_WQ_RD  = 4'd2;
    localparam logic [3:0] ST_WQ_CHK = 4'd3;
    localparam logic [3:0] ST_HQ_ROW = 4'd4;
    localparam logic [3:0] ST_HQ_RD  = 4'd5;
    localparam logic [3:0] ST_HQ_CHK = 4'd6;
    localparam logic [3:0] ST_CLR    = 4'd7;
    localparam logic [3:0] ST_DONE   = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_START;
                end
            end
            ST_START: begin
                unique case (stat.action)
                    ACT_SET: begin
                        cmd.set_we = 1'b1;
                        state_next = ST_DONE;
                    end
                    ACT_WIDTH:  state_next = ST_WQ_RD;
                    ACT_HEIGHT: state_next = ST_HQ_ROW;
                    ACT_CLEAR: begin
                        if (stat.wclip_zero || stat.hclip_zero) begin
                            state_next = ST_DONE;
                        end else begin
                            state_next = ST_CLR;
                        end
                    end
                    default: state_next = ST_DONE;
                endcase
            end
            ST_WQ_RD: begin
                if (stat.w_end) begin
                    state_next = ST_DONE;
                end else begin
                    cmd.rd_en  = 1'b1;
                    state_next = ST_WQ_CHK;
                end
            end
            ST_WQ_CHK: begin
                if (stat.match) begin
                    cmd.ext_inc = 1'b1;
                    state_next  = ST_WQ_RD;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_HQ_ROW: begin
                priority if (stat.h_end) begin
                    state_next = ST_DONE;
                end else if (stat.wclip_zero) begin
                    cmd.ext_inc = 1'b1;
                end else begin
                    state_next = ST_HQ_RD;
                end
            end
            ST_HQ_RD: begin
                cmd.rd_en  = 1'b1;
                state_next = ST_HQ_CHK;
            end
            ST_HQ_CHK: begin
                priority if (!stat.match) begin
                    state_next = ST_DONE;
                end else if (stat.k_last) begin
                    cmd.k_clr   = 1'b1;
                    cmd.ext_inc = 1'b1;
                    state_next  = ST_HQ_ROW;
                end else begin
                    cmd.k_inc  = 1'b1;
                    state_next = ST_HQ_RD;
                end
            end
            ST_CLR: begin
                cmd.clr_we = 1'b1;
                if (stat.k_last) begin
                    cmd.k_clr = 1'b1;
                    if (stat.l_last) begin
                        state_next = ST_DONE;
                    end else begin
                        cmd.l_inc = 1'b1;
                    end
                end else begin
                    cmd.k_inc = 1'b1;
                end
            end
            ST_DONE: begin
                if (!stat.out_full || out_ready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: rtl/gmfm_dp.sv
module gmfm_dp
    import gmfm_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic                   cfg_index,
    input  logic [CFG_BITS-1:0]    cfg_wdata,
    input  logic [S_DATA_BITS-1:0] in_data,
    input  dp_cmd_t                cmd,
    output dp_stat_t               stat,
    input  logic                   out_ready,
    output logic                   out_valid,
    output logic [EXT_BITS-1:0]    out_extent
);

    logic [CFG_BITS-1:0] cols_cfg_reg;
    logic [CFG_BITS-1:0] rows_cfg_reg;

    logic [ACT_BITS-1:0]  act_reg;
    logic [POS_BITS-1:0]  col_reg;
    logic [POS_BITS-1:0]  row_reg;
    cell_t                set_cell_reg;
    cell_t                probe_reg;
    logic [SIZE_BITS-1:0] rw_reg;
    logic [SIZE_BITS-1:0] rh_reg;

    logic [EXT_BITS-1:0]  ext_reg;
    logic [SIZE_BITS-1:0] k_reg;
    logic [SIZE_BITS-1:0] l_reg;

    logic                 out_valid_reg;
    logic [EXT_BITS-1:0]  out_extent_reg;

    // unpacked input word
    logic [ACT_BITS-1:0]  in_act;
    logic [VTYP_BITS-1:0] in_cur_type;
    logic                 in_cur_vis;
    logic [VTYP_BITS-1:0] in_nbr_type;
    logic                 in_nbr_vis;
    cell_t                in_set_cell;

    logic [CFG_BITS-1:0]  cols_eff;
    logic [CFG_BITS-1:0]  rows_eff;
    logic                 col_ok;
    logic                 row_ok;
    logic [CFG_BITS-1:0]  cols_left;
    logic [CFG_BITS-1:0]  rows_left;
    logic [SIZE_BITS-1:0] wclip;
    logic [SIZE_BITS-1:0] hclip;
    logic [SUM_BITS-1:0]  col_ext;
    logic [SUM_BITS-1:0]  row_ext;
    logic [SUM_BITS-1:0]  col_k;
    logic [SUM_BITS-1:0]  row_l;
    logic [SIZE_BITS-1:0] k_plus;
    logic [SIZE_BITS-1:0] l_plus;

    logic [ADDR_BITS-1:0] rd_addr;
    logic [ADDR_BITS-1:0] wr_addr;
    logic                 wr_en;
    cell_t                wr_data;
    cell_t                rd_data;

    assign in_act      = in_data[1:0];
    assign in_cur_type = in_data[19:12];
    assign in_cur_vis  = in_data[20];
    assign in_nbr_type = in_data[28:21];
    assign in_nbr_vis  = in_data[29];

    always_comb begin
        priority if (in_cur_vis == in_nbr_vis) begin
            in_set_cell = {{TYPE_BITS{1'b0}}, SIGN_NONE};
        end else if (in_cur_vis) begin
            in_set_cell = {in_cur_type[TYPE_BITS-1:0], SIGN_POS};
        end else begin
            in_set_cell = {in_nbr_type[TYPE_BITS-1:0], SIGN_NEG};
        end
    end

    // area in use, clipped to the mask size
    assign cols_eff = (cols_cfg_reg > CFG_BITS'(MAX_COLS)) ? CFG_BITS'(MAX_COLS) : cols_cfg_reg;
    assign rows_eff = (rows_cfg_reg > CFG_BITS'(MAX_ROWS)) ? CFG_BITS'(MAX_ROWS) : rows_cfg_reg;

    assign col_ok    = CFG_BITS'(col_reg) < cols_eff;
    assign row_ok    = CFG_BITS'(row_reg) < rows_eff;
    assign cols_left = cols_eff - CFG_BITS'(col_reg);
    assign rows_left = rows_eff - CFG_BITS'(row_reg);
    assign wclip     = (rw_reg < cols_left) ? rw_reg : cols_left;
    assign hclip     = (rh_reg < rows_left) ? rh_reg : rows_left;

    assign col_ext = SUM_BITS'(col_reg) + SUM_BITS'(ext_reg);
    assign row_ext = SUM_BITS'(row_reg) + SUM_BITS'(ext_reg);
    assign col_k   = SUM_BITS'(col_reg) + SUM_BITS'(k_reg);
    assign row_l   = SUM_BITS'(row_reg) + SUM_BITS'(l_reg);
    assign k_plus  = k_reg + 1'b1;
    assign l_plus  = l_reg + 1'b1;

    always_comb begin
        stat            = '0;
        stat.action     = act_reg;
        // a row outside the area has no matching cell
        stat.w_end      = (col_ext >= SUM_BITS'(cols_eff)) || !row_ok;
        stat.h_end      = row_ext >= SUM_BITS'(rows_eff);
        stat.wclip_zero = !col_ok || (rw_reg == '0);
        stat.hclip_zero = !row_ok || (rh_reg == '0);
        stat.k_last     = k_plus == wclip;
        stat.l_last     = l_plus == hclip;
        stat.match      = rd_data == probe_reg;
        stat.out_full   = out_valid_reg;
    end

    assign rd_addr = (act_reg == ACT_WIDTH)
                   ? cell_addr(row_reg, col_ext[POS_BITS-1:0])
                   : cell_addr(row_ext[POS_BITS-1:0], col_k[POS_BITS-1:0]);

    assign wr_addr = cmd.set_we ? cell_addr(row_reg, col_reg)
                                : cell_addr(row_l[POS_BITS-1:0], col_k[POS_BITS-1:0]);
    assign wr_data = cmd.set_we ? set_cell_reg : {{TYPE_BITS{1'b0}}, SIGN_NONE};
    assign wr_en   = (cmd.set_we && col_ok && row_ok) || cmd.clr_we;

    gmfm_ram #(
        .WIDTH (CELL_BITS),
        .DEPTH (CELLS)
    ) u_mask (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (cmd.rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cols_cfg_reg <= CFG_RESET_COLS;
            rows_cfg_reg <= CFG_RESET_ROWS;
        end else if (cfg_wr_en) begin
            if (cfg_index == CFG_COLS) begin
                cols_cfg_reg <= cfg_wdata;
            end
            if (cfg_index == CFG_ROWS) begin
                rows_cfg_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            act_reg      <= in_act;
            col_reg      <= in_data[6:2];
            row_reg      <= in_data[11:7];
            set_cell_reg <= in_set_cell;
            probe_reg    <= {in_data[30 +: TYPE_BITS], in_data[39:38]};
            rw_reg       <= in_data[45:40];
            rh_reg       <= in_data[51:46];
            ext_reg      <= ((in_act == ACT_WIDTH) || (in_act == ACT_HEIGHT))
                          ? EXT_BITS'(1) : '0;
            k_reg        <= '0;
            l_reg        <= '0;
        end else begin
            if (cmd.ext_inc) begin
                ext_reg <= ext_reg + 1'b1;
            end
            if (cmd.k_clr) begin
                k_reg <= '0;
            end else if (cmd.k_inc) begin
                k_reg <= k_plus;
            end
            if (cmd.l_inc) begin
                l_reg <= l_plus;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_extent_reg <= ext_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_extent = out_extent_reg;

endmodule

FILE: rtl/greedy_mesh_face_mask.sv
// channel   direction  handshake              payload
// s_        in         s_tvalid / s_tready    one action word on s_tdata
// m_        out        m_tvalid / m_tready    one extent word on m_tdata
// cfg_      in         cfg_wr_en              cfg_index selects, cfg_wdata value
//
// one word at a time; a width query reads one cell per probe until a mismatch or the
// area edge ends the run (one registered ram read per probe), a height query reads
// the clipped width of each row, a clear writes clipped width * clipped height cells
// synchronous active-low reset; mask contents are not cleared by reset
// a new word is taken while the previous result still waits on m_; a full
// result register holds the sequencer in its last state until m_tready
module greedy_mesh_face_mask
    import gmfm_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,

    // configuration writes: index 0 cols_in_use, index 1 rows_in_use
    input  logic                   cfg_wr_en,
    input  logic                   cfg_index,
    input  logic [CFG_BITS-1:0]    cfg_wdata,

    // input words
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // action[1:0], col[6:2], row[11:7], cur_type[19:12], cur_visible[20],
    // nbr_type[28:21], nbr_visible[29], probe_type[37:30], probe_sign[39:38],
    // rect_width[45:40], rect_height[51:46], zero fill[55:52]
    input  logic [S_DATA_BITS-1:0] s_tdata,

    // result words
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // extent[5:0], zero fill[7:6]
    output logic [M_DATA_BITS-1:0] m_tdata
);

    dp_cmd_t             cmd;
    dp_stat_t            stat;
    logic [EXT_BITS-1:0] extent;

    // sequencer for the action in progress
    gmfm_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_ready (m_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // field registers, counters, mask ram and result register
    gmfm_dp u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .in_data    (s_tdata),
        .cmd        (cmd),
        .stat       (stat),
        .out_ready  (m_tready),
        .out_valid  (m_tvalid),
        .out_extent (extent)
    );

    assign m_tdata = {{(M_DATA_BITS-EXT_BITS){1'b0}}, extent};

endmodule

FILE: test/mask_extent_check.sv
module mask_extent_check
    import gmfm_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic                   cfg_index,
    input  logic [CFG_BITS-1:0]    cfg_wdata,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [S_DATA_BITS-1:0] s_tdata,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [M_DATA_BITS-1:0] m_tdata,
    output int unsigned            waiting,
    output int unsigned            mismatches
);

    // fields of an action word, lowest bits last
    typedef struct packed {
        logic [S_DATA_BITS-53:0] fill;
        logic [SIZE_BITS-1:0]    rect_height;
        logic [SIZE_BITS-1:0]    rect_width;
        logic [SIGN_BITS-1:0]    probe_sign;
        logic [VTYP_BITS-1:0]    probe_type;
        logic                    nbr_visible;
        logic [VTYP_BITS-1:0]    nbr_type;
        logic                    cur_visible;
        logic [VTYP_BITS-1:0]    cur_type;
        logic [POS_BITS-1:0]     row;
        logic [POS_BITS-1:0]     col;
        logic [ACT_BITS-1:0]     action;
    } action_word_t;

    cell_t                  face_mask [CELLS];
    logic [CFG_BITS-1:0]    cols_reg = CFG_RESET_COLS;
    logic [CFG_BITS-1:0]    rows_reg = CFG_RESET_ROWS;
    logic [M_DATA_BITS-1:0] expected_extents [$];

    initial begin
        foreach (face_mask[i]) face_mask[i] = '0;
    end

    function automatic int area_cols();
        return (cols_reg > MAX_COLS) ? MAX_COLS : int'(cols_reg);
    endfunction

    function automatic int area_rows();
        return (rows_reg > MAX_ROWS) ? MAX_ROWS : int'(rows_reg);
    endfunction

    function automatic bit in_area(int c, int r);
        return c < area_cols() && r < area_rows();
    endfunction

    // cells outside the area never match
    function automatic bit face_hits(int c, int r, cell_t probe);
        if (!in_area(c, r)) return 1'b0;
        return face_mask[r * MAX_COLS + c] == probe;
    endfunction

    function automatic void put_face(int c, int r, cell_t face);
        if (in_area(c, r)) face_mask[r * MAX_COLS + c] = face;
    endfunction

    function automatic logic [EXT_BITS-1:0] mask_action_extent(action_word_t w);
        cell_t probe;
        cell_t face;
        int    cols, rows, c, r, rw, rh, ext, wclip, k, l;
        bit    stop;
        probe = {w.probe_type[TYPE_BITS-1:0], w.probe_sign};
        cols  = area_cols();
        rows  = area_rows();
        c     = w.col;
        r     = w.row;
        rw    = w.rect_width;
        rh    = w.rect_height;
        ext   = 0;
        case (w.action)
            ACT_SET: begin
                if (w.cur_visible == w.nbr_visible)
                    face = {{TYPE_BITS{1'b0}}, SIGN_NONE};
                else if (w.cur_visible)
                    face = {w.cur_type[TYPE_BITS-1:0], SIGN_POS};
                else
                    face = {w.nbr_type[TYPE_BITS-1:0], SIGN_NEG};
                put_face(c, r, face);
            end
            ACT_WIDTH: begin
                ext = 1;
                while (c + ext < cols && face_hits(c + ext, r, probe)) ext++;
            end
            ACT_HEIGHT: begin
                wclip = 0;
                if (c < cols) wclip = (rw < cols - c) ? rw : cols - c;
                ext  = 1;
                stop = 1'b0;
                while (!stop && r + ext < rows) begin
                    for (k = 0; k < wclip && !stop; k++)
                        if (!face_hits(c + k, r + ext, probe)) stop = 1'b1;
                    if (!stop) ext++;
                end
            end
            default: begin
                for (l = 0; l < rh; l++)
                    for (k = 0; k < rw; k++)
                        put_face(c + k, r + l, '0);
            end
        endcase
        return ext[EXT_BITS-1:0];
    endfunction

    always @(posedge aclk) begin : watch
        logic [M_DATA_BITS-1:0] want;
        if (!aresetn) begin
            cols_reg = CFG_RESET_COLS;
            rows_reg = CFG_RESET_ROWS;
            expected_extents.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_extents.size() == 0) begin
                    if (mismatches < 10)
                        $display("extent word %h arrived with nothing expected", m_tdata);
                    mismatches++;
                end else begin
                    want = expected_extents.pop_front();
                    if (m_tdata !== want) begin
                        if (mismatches < 10)
                            $display("extent mismatch: expected %0d (word %h), got %0d (word %h)",
                                     want[EXT_BITS-1:0], want, m_tdata[EXT_BITS-1:0], m_tdata);
                        mismatches++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                expected_extents.push_back({{(M_DATA_BITS-EXT_BITS){1'b0}},
                                            mask_action_extent(action_word_t'(s_tdata))});
            if (cfg_wr_en) begin
                if (cfg_index == CFG_COLS) cols_reg = cfg_wdata;
                else rows_reg = cfg_wdata;
            end
        end
        waiting <= expected_extents.size();
    end

endmodule

FILE: test/tb_greedy_mesh_face_mask.sv
module tb_greedy_mesh_face_mask;
    import gmfm_pkg::*;

    // cycles with no word moving on either side before the run is called dead
    localparam int QUIET_LIMIT = 20000;
    localparam int WORD_GOAL   = 650;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic                   cfg_index = CFG_COLS;
    logic [CFG_BITS-1:0]    cfg_wdata = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    // action, col, row, cur_type, cur_visible, nbr_type, nbr_visible,
    // probe_type, probe_sign, rect_width, rect_height, zero fill
    logic [S_DATA_BITS-1:0] s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    // extent, zero fill
    logic [M_DATA_BITS-1:0] m_tdata;

    int unsigned waiting;
    int unsigned mismatches;

    // idling switches, changed per phase
    bit          idle_en  = 1'b1;
    bit          stall_en = 1'b1;
    int unsigned ready_hold = 0;
    int unsigned quiet      = 0;
    int unsigned words_sent = 0;

    // area the random part aims at, follows the last configuration
    int aim_cols = MAX_COLS;
    int aim_rows = MAX_ROWS;

    always #1 aclk = ~aclk;

    greedy_mesh_face_mask u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    mask_extent_check u_extent_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .waiting    (waiting),
        .mismatches (mismatches)
    );

    // receiver: ready/not-ready spells, mostly short, now and then long
    always @(posedge aclk) begin
        if (!stall_en) begin
            m_tready   <= 1'b1;
            ready_hold <= 0;
        end else if (ready_hold != 0) begin
            ready_hold <= ready_hold - 1;
        end else begin
            m_tready   <= ($urandom_range(0, 99) < 60);
            ready_hold <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 50)
                                                      : $urandom_range(0, 3);
        end
    end

    // watchdog on words moving either way
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
            if (quiet >= QUIET_LIMIT) begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // sender gap after each word, none when idling is off
    function automatic int pick_gap();
        int r;
        if (!idle_en) return 0;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // register values: extremes, zero now and then, above the maximum too
    function automatic logic [CFG_BITS-1:0] pick_reg_value();
        case ($urandom_range(0, 9))
            0:       return 6'd1;
            1:       return 6'd32;
            2:       return CFG_BITS'($urandom_range(33, 63));
            3:       return ($urandom_range(0, 3) == 0) ? 6'd0 : 6'd2;
            default: return CFG_BITS'($urandom_range(2, 32));
        endcase
    endfunction

    function automatic logic [S_DATA_BITS-1:0] pack_word(
        input logic [ACT_BITS-1:0]  act,
        input logic [POS_BITS-1:0]  col,
        input logic [POS_BITS-1:0]  row,
        input logic [VTYP_BITS-1:0] ct,
        input logic                 cv,
        input logic [VTYP_BITS-1:0] nt,
        input logic                 nv,
        input logic [VTYP_BITS-1:0] pt,
        input logic [SIGN_BITS-1:0] ps,
        input logic [SIZE_BITS-1:0] rw,
        input logic [SIZE_BITS-1:0] rh
    );
        return {{(S_DATA_BITS-52){1'b0}}, rh, rw, ps, pt, nv, nt, cv, ct, row, col, act};
    endfunction

    // hold the word until taken, then maybe drop valid for a gap
    task automatic send_word(input logic [S_DATA_BITS-1:0] word);
        int gap;
        s_tdata  <= word;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        words_sent++;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // fields an action does not use get random content
    task automatic do_set(input int c, input int r, input logic [7:0] ct, input logic cv,
                          input logic [7:0] nt, input logic nv);
        send_word(pack_word(ACT_SET, POS_BITS'(c), POS_BITS'(r), ct, cv, nt, nv,
                            8'($urandom), 2'($urandom), 6'($urandom), 6'($urandom)));
    endtask

    task automatic do_width(input int c, input int r, input logic [7:0] pt,
                            input logic [1:0] ps);
        send_word(pack_word(ACT_WIDTH, POS_BITS'(c), POS_BITS'(r), 8'($urandom),
                            1'($urandom), 8'($urandom), 1'($urandom), pt, ps,
                            6'($urandom), 6'($urandom)));
    endtask

    task automatic do_height(input int c, input int r, input logic [7:0] pt,
                             input logic [1:0] ps, input int rw);
        send_word(pack_word(ACT_HEIGHT, POS_BITS'(c), POS_BITS'(r), 8'($urandom),
                            1'($urandom), 8'($urandom), 1'($urandom), pt, ps,
                            SIZE_BITS'(rw), 6'($urandom)));
    endtask

    task automatic do_clear(input int c, input int r, input int rw, input int rh);
        send_word(pack_word(ACT_CLEAR, POS_BITS'(c), POS_BITS'(r), 8'($urandom),
                            1'($urandom), 8'($urandom), 1'($urandom), 8'($urandom),
                            2'($urandom), SIZE_BITS'(rw), SIZE_BITS'(rh)));
    endtask

    // set one cell to a given face by choosing the voxel pair that makes it
    task automatic set_face(input int c, input int r, input logic [7:0] ft,
                            input logic [1:0] fs);
        logic v;
        v = 1'($urandom);
        case (fs)
            SIGN_POS: do_set(c, r, ft, 1'b1, 8'($urandom), 1'b0);
            SIGN_NEG: do_set(c, r, 8'($urandom), 1'b0, ft, 1'b1);
            default:  do_set(c, r, 8'($urandom), v, 8'($urandom), v);
        endcase
    endtask

    // stop sending and wait until every extent is back
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (waiting != 0) @(posedge aclk);
    endtask

    // both registers, back to back, only while the block is idle
    task automatic configure(input logic [CFG_BITS-1:0] cols_v,
                             input logic [CFG_BITS-1:0] rows_v);
        cfg_index <= CFG_COLS;
        cfg_wdata <= cols_v;
        cfg_wr_en <= 1'b1;
        @(posedge aclk);
        cfg_index <= CFG_ROWS;
        cfg_wdata <= rows_v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        aim_cols = (cols_v > MAX_COLS) ? MAX_COLS : ((cols_v == 0) ? 1 : int'(cols_v));
        aim_rows = (rows_v > MAX_ROWS) ? MAX_ROWS : ((rows_v == 0) ? 1 : int'(rows_v));
    endtask

    // paint a rectangle with one face, then query and maybe clear it
    task automatic fill_and_probe();
        int         c0, r0, w, h, i, j, n, c, r;
        logic [7:0] ft;
        logic [1:0] fs;
        case ($urandom_range(0, 3))
            0:       ft = 8'h00;
            1:       ft = 8'hff;
            default: ft = 8'($urandom);
        endcase
        case ($urandom_range(0, 4))
            0:       fs = SIGN_NONE;
            1, 2:    fs = SIGN_POS;
            default: fs = SIGN_NEG;
        endcase
        if (fs == SIGN_NONE) ft = 8'h00;
        c0 = $urandom_range(0, aim_cols - 1);
        r0 = $urandom_range(0, aim_rows - 1);
        w  = $urandom_range(1, (aim_cols - c0 < 8) ? aim_cols - c0 : 8);
        h  = $urandom_range(1, (aim_rows - r0 < 6) ? aim_rows - r0 : 6);
        // now and then a long strip for long width runs
        if ($urandom_range(0, 9) == 0) begin
            w = $urandom_range(1, aim_cols - c0);
            h = $urandom_range(1, (aim_rows - r0 < 2) ? aim_rows - r0 : 2);
        end
        for (j = 0; j < h; j++)
            for (i = 0; i < w; i++)
                if ($urandom_range(0, 19) == 0)
                    do_set(c0 + i, r0 + j, 8'($urandom), 1'($urandom), 8'($urandom),
                           1'($urandom));
                else
                    set_face(c0 + i, r0 + j, ft, fs);
        n = $urandom_range(1, 3);
        for (i = 0; i < n; i++) begin
            // mostly the painted face, sometimes a stray or never-matching probe
            if ($urandom_range(0, 9) == 0) begin
                ft = 8'($urandom);
                fs = 2'($urandom);
            end
            if ($urandom_range(0, 1) == 0) begin
                r = r0 + $urandom_range(0, h - 1);
                c = (c0 > 0 && $urandom_range(0, 1)) ? c0 - 1 : c0 + $urandom_range(0, w - 1);
                do_width(c, r, ft, fs);
            end else begin
                c = c0 + $urandom_range(0, w - 1);
                r = (r0 > 0 && $urandom_range(0, 1)) ? r0 - 1 : r0;
                do_height(c, r, ft, fs, $urandom_range(0, w + 1));
            end
        end
        if ($urandom_range(0, 3) == 0) do_clear(c0, r0, w, h);
    endtask

    // a few words with every field random
    task automatic noise_words();
        int n, i, rw, rh;
        n = $urandom_range(1, 4);
        for (i = 0; i < n; i++) begin
            rw = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 8);
            rh = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 8);
            send_word(pack_word(2'($urandom), 5'($urandom), 5'($urandom), 8'($urandom),
                                1'($urandom), 8'($urandom), 1'($urandom), 8'($urandom),
                                2'($urandom), SIZE_BITS'(rw), SIZE_BITS'(rh)));
        end
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // whole mask emptied first so no cell is ever read unwritten
        do_clear(0, 0, 32, 32);
        // visible current voxel, two in a row, then both equal-visibility cases
        do_set(0, 0, 8'hff, 1'b1, 8'h5a, 1'b0);
        do_set(1, 0, 8'hff, 1'b1, 8'h00, 1'b0);
        do_set(2, 0, 8'hff, 1'b1, 8'hff, 1'b1);
        do_set(3, 0, 8'h81, 1'b0, 8'h7e, 1'b0);
        // neighbour faces in the far corner
        do_set(31, 31, 8'hff, 1'b0, 8'h00, 1'b1);
        do_set(30, 31, 8'h3c, 1'b0, 8'h00, 1'b1);
        do_width(0, 0, 8'hff, SIGN_POS);
        do_width(1, 0, 8'h00, SIGN_NONE);
        do_width(31, 0, 8'h00, SIGN_NONE);
        do_width(29, 31, 8'h00, SIGN_NEG);
        do_height(30, 30, 8'h00, SIGN_NEG, 2);
        // zero width checks nothing, oversized width is clipped
        do_height(0, 0, 8'h00, SIGN_NONE, 0);
        do_height(5, 0, 8'h00, SIGN_NONE, 63);
        // sign code that matches no cell
        do_width(0, 5, 8'h00, 2'b10);
        do_height(0, 0, 8'h00, 2'b10, 1);
        // clear running off the area, and zero-sized clears
        do_clear(30, 31, 63, 63);
        do_clear(0, 0, 0, 5);
        do_clear(0, 0, 5, 0);
        do_width(0, 0, 8'hff, SIGN_POS);

        // smallest area: queries end at once, an outside set is dropped
        wait_idle();
        configure(6'd1, 6'd1);
        do_width(0, 0, 8'h00, SIGN_NONE);
        do_height(0, 0, 8'h00, SIGN_NONE, 32);
        do_set(5, 5, 8'h07, 1'b1, 8'h00, 1'b0);

        // values above the maximum act as the maximum
        wait_idle();
        configure(6'd63, 6'd63);
        do_width(4, 5, 8'h07, SIGN_POS);
        do_height(0, 0, 8'h00, SIGN_NONE, 32);

        // random part
        while (words_sent < WORD_GOAL) begin
            idle_en  = ($urandom_range(0, 3) != 0);
            stall_en = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 99) < 12) begin
                wait_idle();
                configure(pick_reg_value(), pick_reg_value());
            end
            if ($urandom_range(0, 9) < 7) fill_and_probe();
            else noise_words();
        end

        // drain, then wait a little longer for anything stray
        wait_idle();
        repeat (20) @(posedge aclk);
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
